FILE: rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// itoa_pkg: shared constants, types and functions for the radix text block
// Holds the field widths, ASCII codes, radix limits, the divider status
// struct and the digit-to-character conversion.
// ============================================================================
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd9;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Commands from the sequencer to the serial divider.
    typedef struct packed {
        logic load;   // start a new division on a fresh dividend
        logic next;   // divide the held quotient again
    } t_div_cmd;

    // Status from the serial divider back to the sequencer.
    typedef struct packed {
        logic               done;   // remainder and quotient are final
        logic               more;   // quotient is nonzero
        logic [RADIX_W-1:0] digit;  // remainder of this division
    } t_div_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX) begin
            c = ASCII_A + CHAR_W'(d - RADIX_DEC);
        end else begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

FILE: rtl/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// ============================================================================
// integer_to_ascii_radix: integer to text in a base from 2 to 36, signed in base ten
// Converts one value into ASCII characters, most significant first, with a
// leading minus sign for negative values in base ten.
// ============================================================================
//
// Channel    Direction  Handshake                  Payload
// ---------  ---------  -------------------------  -------------------------
// command    in         start high, busy low       i_value
// result     out        o_strobe, one cycle        o_character, o_last_char
// config     in         i_cfg_valid & o_cfg_ready  i_cfg_data (radix)
//
// Each digit costs one pass of the bit-serial divider. Once all digits are
// stacked, the minus sign, if any, is presented, and then each character is
// read from the stack and then strobed.
// Reset is synchronous and active low; it returns the radix to ten and the
// sequencer to idle. The receiver cannot stall, so every character is
// presented for exactly one cycle and busy stays high until the last one.
//
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic [itoa_pkg::CHAR_W-1:0]   o_character,
    output logic                          o_last_char,
    output logic                          o_strobe,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a command beat
    localparam logic [2:0] S_DIV  = 3'd1;  // divider producing digits
    localparam logic [2:0] S_SIGN = 3'd2;  // presenting the minus sign
    localparam logic [2:0] S_POP  = 3'd3;  // reading the next digit
    localparam logic [2:0] S_SHOW = 3'd4;  // presenting a digit

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [itoa_pkg::RADIX_W-1:0] r_radix;
    logic [itoa_pkg::RADIX_W-1:0] n_radix;
    logic                         r_neg;
    logic                         n_neg;

    logic                         w_accept;
    logic                         w_neg_in;
    logic [VALUE_BITS-1:0]        w_dividend;
    itoa_pkg::t_div_cmd           w_cmd;
    itoa_pkg::t_div_sts           w_sts;
    logic                         w_push;
    logic                         w_pop;
    logic [itoa_pkg::RADIX_W-1:0] w_digit;
    logic                         w_empty;

    // The radix register always accepts a write. The value is clamped to the
    // legal range as it is stored, so the datapath only ever sees 2 to 36.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_radix = r_radix;
        if (i_cfg_valid) begin
            if (i_cfg_data < itoa_pkg::RADIX_MIN) begin
                n_radix = itoa_pkg::RADIX_MIN;
            end else if (i_cfg_data > itoa_pkg::RADIX_MAX) begin
                n_radix = itoa_pkg::RADIX_MAX;
            end else begin
                n_radix = i_cfg_data;
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Only base ten shows a sign. Negating the most negative value leaves the
    // same bit pattern, which read as unsigned is exactly its magnitude.
    assign w_neg_in   = (r_radix == itoa_pkg::RADIX_DEC) && i_value[VALUE_BITS-1];
    assign w_dividend = w_neg_in ? (~i_value + 1'b1) : i_value;

    // The divider always yields at least one digit, so a zero value gives a
    // single '0' with no special handling.
    always_comb begin
        n_state    = r_state;
        n_neg      = r_neg;
        w_cmd.load = 1'b0;
        w_cmd.next = 1'b0;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load = 1'b1;
                    n_neg      = w_neg_in;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (w_sts.done) begin
                    w_push = 1'b1;
                    if (w_sts.more) begin
                        w_cmd.next = 1'b1;
                    end else if (r_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_SIGN: begin
                n_state = S_POP;
            end
            S_POP: begin
                w_pop   = 1'b1;
                n_state = S_SHOW;
            end
            S_SHOW: begin
                n_state = w_empty ? S_IDLE : S_POP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= itoa_pkg::RADIX_RESET;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_radix <= n_radix;
            r_neg   <= n_neg;
        end
    end

    itoa_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_dividend (w_dividend),
        .i_radix    (r_radix),
        .o_sts      (w_sts)
    );

    itoa_stack #(
        .VALUE_BITS (VALUE_BITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_sts.digit),
        .i_pop   (w_pop),
        .o_rdata (w_digit),
        .o_empty (w_empty)
    );

    // The stack pointer has already moved past the digit being shown, so an
    // empty stack in the show state marks the final character.
    assign o_strobe    = (r_state == S_SIGN) || (r_state == S_SHOW);
    assign o_last_char = (r_state == S_SHOW) && w_empty;
    assign o_character = (r_state == S_SIGN) ? itoa_pkg::ASCII_MINUS
                                             : itoa_pkg::digit_char(w_digit);

endmodule

FILE: rtl/itoa_div.sv
`timescale 1ns / 1ps
// ============================================================================
// itoa_div: bit-serial restoring divider by a small radix
// Shifts the dividend out one bit per cycle into a narrow remainder and
// shifts the quotient bits back into the same register.
// ============================================================================
module itoa_div #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  itoa_pkg::t_div_cmd           i_cmd,
    input  logic [VALUE_BITS-1:0]        i_dividend,
    input  logic [itoa_pkg::RADIX_W-1:0] i_radix,
    output itoa_pkg::t_div_sts           o_sts
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]         r_q;
    logic [itoa_pkg::RADIX_W-1:0]  r_rem;
    logic [CW-1:0]                 r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic                          r_nz;

    logic [itoa_pkg::RADIX_W:0]    w_cand;
    logic                          w_ge;
    logic [itoa_pkg::RADIX_W:0]    w_diff;

    // Partial remainder with the next dividend bit brought down.
    assign w_cand = {r_rem, r_q[VALUE_BITS-1]};
    assign w_ge   = (w_cand >= {1'b0, i_radix});
    assign w_diff = w_cand - {1'b0, i_radix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load || i_cmd.next) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_nz  <= 1'b0;
        end else if (i_cmd.next) begin
            r_rem <= '0;
            r_nz  <= 1'b0;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[itoa_pkg::RADIX_W-1:0] : w_cand[itoa_pkg::RADIX_W-1:0];
            r_nz  <= r_nz | w_ge;
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.more  = r_nz;
    assign o_sts.digit = r_rem;

endmodule

FILE: rtl/itoa_stack.sv
`timescale 1ns / 1ps
// ============================================================================
// itoa_stack: last-in first-out store for the digits of one value
// Digits arrive least significant first and leave most significant first.
// ============================================================================
module itoa_stack #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [itoa_pkg::RADIX_W-1:0] i_wdata,
    input  logic                         i_pop,
    output logic [itoa_pkg::RADIX_W-1:0] o_rdata,
    output logic                         o_empty
);

    localparam int DEPTH = VALUE_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [itoa_pkg::RADIX_W-1:0] r_mem [DEPTH];
    logic [CW-1:0]                r_ptr;
    logic [CW-1:0]                w_top;
    logic [itoa_pkg::RADIX_W-1:0] r_rdata;

    assign w_top = r_ptr - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_push) begin
            r_ptr <= r_ptr + 1'b1;
        end else if (i_pop) begin
            r_ptr <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_ptr[AW-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_rdata <= r_mem[w_top[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
    assign o_empty = (r_ptr == '0);

endmodule
